/* rtl/core/slmn_pkg.sv */
`timescale 1ns / 1ps

package slmn_pkg;

    localparam int SWITCH_COUNT_DEF = 8;
    localparam int MAX_SWITCHES     = 8;
    localparam int IDX_W            = 3;
    localparam int LOCK_W           = 16;
    localparam int NOTE_W           = 7;
    localparam int CHAN_W           = 4;
    localparam int CFG_W            = 16;
    localparam int CFG_IDX_W        = 2;

    localparam logic [LOCK_W-1:0] LOCK_RST = LOCK_W'(50);
    localparam logic [NOTE_W-1:0] BASE_RST = NOTE_W'(8'h3C);
    localparam logic [NOTE_W-1:0] VEL_RST  = NOTE_W'(127);
    localparam logic [CHAN_W-1:0] CHAN_RST = CHAN_W'(0);
    localparam logic [NOTE_W-1:0] NOTE_MAX = NOTE_W'(127);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCKOUT_TICKS = 2'd0,
        CFG_BASE_NOTE     = 2'd1,
        CFG_NOTE_VELOCITY = 2'd2,
        CFG_MIDI_CHANNEL  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    typedef struct packed {
        logic              start;
        logic              fire;
        logic              advance;
        logic [LOCK_W-1:0] lock_ticks;
    } t_cell_ctl;

    typedef struct packed {
        logic hit;
        logic note_on;
        logic last;
    } t_cell_sel;

    function automatic logic [NOTE_W-1:0] scale_offset(input logic [IDX_W-1:0] idx);
        logic [NOTE_W-1:0] off;
        begin
            case (idx)
                3'd0:    off = NOTE_W'(0);
                3'd1:    off = NOTE_W'(2);
                3'd2:    off = NOTE_W'(4);
                3'd3:    off = NOTE_W'(5);
                3'd4:    off = NOTE_W'(7);
                3'd5:    off = NOTE_W'(9);
                3'd6:    off = NOTE_W'(11);
                default: off = NOTE_W'(12);
            endcase
            return off;
        end
    endfunction

    function automatic logic [NOTE_W-1:0] note_of(input logic [NOTE_W-1:0] base,
                                                  input logic [IDX_W-1:0]  idx);
        logic [NOTE_W:0] sum;
        begin
            sum = {1'b0, base} + {1'b0, scale_offset(idx)};
            return (sum > {1'b0, NOTE_MAX}) ? NOTE_MAX : sum[NOTE_W-1:0];
        end
    endfunction

endpackage

/* rtl/core/slmn_cell.sv */
`timescale 1ns / 1ps

module slmn_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  slmn_pkg::t_cell_ctl   i_ctl,
    input  logic                  i_level,
    input  logic                  i_tok,
    output logic                  o_tok,
    input  logic                  i_above,
    output logic                  o_above,
    input  slmn_pkg::t_cell_sel   i_sel,
    output slmn_pkg::t_cell_sel   o_sel,
    output logic                  o_fire
);

    logic                          r_stored;
    logic                          r_now;
    logic                          r_pend;
    logic                          r_tok;
    logic [slmn_pkg::LOCK_W-1:0]   r_cnt;
    logic [slmn_pkg::LOCK_W-1:0]   n_cnt;
    logic                          w_now;
    logic                          w_diff;
    logic                          w_emit;
    slmn_pkg::t_cell_sel           w_mine;

    assign w_now  = ~i_level;
    assign w_diff = (w_now != r_stored);
    assign n_cnt  = (r_cnt != '0) ? r_cnt - slmn_pkg::LOCK_W'(1) : r_cnt;
    assign o_fire = w_diff && (n_cnt == '0);
    assign w_emit = r_tok && r_pend && i_ctl.advance;

    assign o_tok   = r_tok;
    assign o_above = r_pend | i_above;

    always_comb begin
        w_mine.hit     = r_pend;
        w_mine.note_on = r_now;
        w_mine.last    = ~i_above;
        o_sel          = r_tok ? w_mine : i_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored <= 1'b0;
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_tok    <= 1'b0;
            r_now    <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_cnt  <= n_cnt;
                r_pend <= i_ctl.fire && w_diff;
                r_now  <= w_now;
            end else if (w_emit) begin
                r_stored <= r_now;
                r_cnt    <= i_ctl.lock_ticks;
                r_pend   <= 1'b0;
            end
            if (i_ctl.start || i_ctl.advance) begin
                r_tok <= i_tok;
            end
        end
    end

endmodule

/* rtl/core/switch_lockout_midi_note_events.sv */
`timescale 1ns / 1ps
// Once a tick that fires is taken, a token walks the switch cells in index order,
// one per cycle unless a pending message is held by output stall; each cell holding
// a message loads it into the registered output, and input stalls until the scan ends.
// A tick with no event does not stall the input and starts no scan.
// Reset (synchronous, active low): all switches off, all lockouts clear,
// registers at defaults; no clearing pass.

module switch_lockout_midi_note_events #(
    parameter int SWITCH_COUNT = slmn_pkg::SWITCH_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [slmn_pkg::MAX_SWITCHES-1:0] i_pin_levels,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_note_on,
    output logic [slmn_pkg::CHAN_W-1:0]     o_channel_out,
    output logic [slmn_pkg::NOTE_W-1:0]     o_note_number,
    output logic [slmn_pkg::NOTE_W-1:0]     o_velocity_out,
    output logic [slmn_pkg::IDX_W-1:0]      o_switch_index,
    output logic                            o_last,
    input  logic                            i_cfg_we,
    input  logic [slmn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slmn_pkg::CFG_W-1:0]      i_cfg_data
);

    slmn_pkg::t_state                 r_state;
    slmn_pkg::t_state                 n_state;
    logic [slmn_pkg::LOCK_W-1:0]      r_lock_ticks;
    logic [slmn_pkg::NOTE_W-1:0]      r_base_note;
    logic [slmn_pkg::NOTE_W-1:0]      r_velocity;
    logic [slmn_pkg::CHAN_W-1:0]      r_channel;
    logic [slmn_pkg::IDX_W-1:0]       r_idx;
    logic                             r_o_valid;
    logic                             r_o_note_on;
    logic [slmn_pkg::CHAN_W-1:0]      r_o_channel;
    logic [slmn_pkg::NOTE_W-1:0]      r_o_note;
    logic [slmn_pkg::NOTE_W-1:0]      r_o_velocity;
    logic [slmn_pkg::IDX_W-1:0]       r_o_index;
    logic                             r_o_last;

    logic                             w_in_acc;
    logic                             w_fire;
    logic                             w_out_free;
    logic                             w_start;
    logic                             w_advance;
    logic                             w_load;
    logic [SWITCH_COUNT:0]            w_tok;
    logic [SWITCH_COUNT:0]            w_above;
    logic [SWITCH_COUNT-1:0]          w_fire_v;
    slmn_pkg::t_cell_sel              w_sel [SWITCH_COUNT+1];
    slmn_pkg::t_cell_ctl              w_ctl;

    assign o_stall    = (r_state != slmn_pkg::ST_IDLE);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_fire     = |w_fire_v;
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_load     = w_advance && w_sel[SWITCH_COUNT].hit;

    always_comb begin
        n_state = r_state;
        case (r_state)
            slmn_pkg::ST_IDLE: begin
                if (w_in_acc && w_fire) n_state = slmn_pkg::ST_SCAN;
            end
            slmn_pkg::ST_SCAN: begin
                if (w_advance && w_tok[SWITCH_COUNT]) n_state = slmn_pkg::ST_IDLE;
            end
            default: n_state = slmn_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_start   = 1'b0;
        w_advance = 1'b0;
        case (r_state)
            slmn_pkg::ST_IDLE: begin
                w_start = w_in_acc;
            end
            slmn_pkg::ST_SCAN: begin
                w_advance = !w_sel[SWITCH_COUNT].hit || w_out_free;
            end
            default: begin
                w_start   = 1'b0;
                w_advance = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_ctl.start      = w_start;
        w_ctl.fire       = w_fire;
        w_ctl.advance    = w_advance;
        w_ctl.lock_ticks = r_lock_ticks;
    end

    assign w_tok[0]               = w_start && w_fire;
    assign w_above[SWITCH_COUNT]  = 1'b0;
    assign w_sel[0]               = '0;

    for (genvar g = 0; g < SWITCH_COUNT; g++) begin : g_cell
        slmn_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_level (i_pin_levels[g]),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .i_above (w_above[g+1]),
            .o_above (w_above[g]),
            .i_sel   (w_sel[g]),
            .o_sel   (w_sel[g+1]),
            .o_fire  (w_fire_v[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= slmn_pkg::ST_IDLE;
            r_lock_ticks <= slmn_pkg::LOCK_RST;
            r_base_note  <= slmn_pkg::BASE_RST;
            r_velocity   <= slmn_pkg::VEL_RST;
            r_channel    <= slmn_pkg::CHAN_RST;
            r_idx        <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    slmn_pkg::CFG_LOCKOUT_TICKS: r_lock_ticks <= i_cfg_data;
                    slmn_pkg::CFG_BASE_NOTE:     r_base_note  <= i_cfg_data[slmn_pkg::NOTE_W-1:0];
                    slmn_pkg::CFG_NOTE_VELOCITY: r_velocity   <= i_cfg_data[slmn_pkg::NOTE_W-1:0];
                    slmn_pkg::CFG_MIDI_CHANNEL:  r_channel    <= i_cfg_data[slmn_pkg::CHAN_W-1:0];
                    default: ;
                endcase
            end
            if (w_start) begin
                r_idx <= '0;
            end else if (w_advance) begin
                r_idx <= r_idx + slmn_pkg::IDX_W'(1);
            end
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_note_on  <= w_sel[SWITCH_COUNT].note_on;
            r_o_channel  <= r_channel;
            r_o_note     <= slmn_pkg::note_of(r_base_note, r_idx);
            r_o_velocity <= r_velocity;
            r_o_index    <= r_idx;
            r_o_last     <= w_sel[SWITCH_COUNT].last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_note_on      = r_o_note_on;
    assign o_channel_out  = r_o_channel;
    assign o_note_number  = r_o_note;
    assign o_velocity_out = r_o_velocity;
    assign o_switch_index = r_o_index;
    assign o_last         = r_o_last;

    a_tok_onehot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok[SWITCH_COUNT:1]))
        else $error("more than one scan token");

    a_scan_has_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slmn_pkg::ST_SCAN) |-> $onehot(w_tok[SWITCH_COUNT:1]))
        else $error("scan without token");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slmn_pkg::ST_IDLE) |-> (w_above[0] == 1'b0))
        else $error("pending message left after scan");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_out_free)
        else $error("message loaded over a held beat");

endmodule

/* verif/midi_note_board_pkg.sv */
`timescale 1ns / 1ps

package midi_note_board_pkg;

    typedef struct packed {
        logic                        note_on;
        logic [slmn_pkg::CHAN_W-1:0] chan;
        logic [slmn_pkg::NOTE_W-1:0] note;
        logic [slmn_pkg::NOTE_W-1:0] vel;
        logic [slmn_pkg::IDX_W-1:0]  sw;
        logic                        last;
    } t_note_msg;

    class midi_note_board;
        logic [slmn_pkg::LOCK_W-1:0] lock_ticks;
        logic [slmn_pkg::NOTE_W-1:0] base_note;
        logic [slmn_pkg::NOTE_W-1:0] velocity;
        logic [slmn_pkg::CHAN_W-1:0] channel;
        logic                        sw_on    [slmn_pkg::MAX_SWITCHES];
        logic [slmn_pkg::LOCK_W-1:0] lock_cnt [slmn_pkg::MAX_SWITCHES];
        logic [slmn_pkg::NOTE_W-1:0] interval [slmn_pkg::MAX_SWITCHES];
        t_note_msg                   pending_notes[$];
        int                          errors;

        function new();
            interval   = '{7'd0, 7'd2, 7'd4, 7'd5, 7'd7, 7'd9, 7'd11, 7'd12};
            lock_ticks = slmn_pkg::LOCK_W'(50);
            base_note  = slmn_pkg::NOTE_W'(60);
            velocity   = slmn_pkg::NOTE_W'(127);
            channel    = '0;
            foreach (sw_on[i]) begin
                sw_on[i]    = 1'b0;
                lock_cnt[i] = '0;
            end
            errors = 0;
        endfunction

        function void write_reg(slmn_pkg::t_cfg_idx idx, logic [slmn_pkg::CFG_W-1:0] data);
            case (idx)
                slmn_pkg::CFG_LOCKOUT_TICKS: lock_ticks = data[slmn_pkg::LOCK_W-1:0];
                slmn_pkg::CFG_BASE_NOTE:     base_note  = data[slmn_pkg::NOTE_W-1:0];
                slmn_pkg::CFG_NOTE_VELOCITY: velocity   = data[slmn_pkg::NOTE_W-1:0];
                slmn_pkg::CFG_MIDI_CHANNEL:  channel    = data[slmn_pkg::CHAN_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_tick(logic [slmn_pkg::MAX_SWITCHES-1:0] pins);
            logic                      now [slmn_pkg::MAX_SWITCHES];
            logic                      fire;
            logic [slmn_pkg::NOTE_W:0] sum;
            t_note_msg                 msg;
            t_note_msg                 burst[$];
            fire = 1'b0;
            foreach (now[i]) begin
                if (lock_cnt[i] != '0) lock_cnt[i] = lock_cnt[i] - slmn_pkg::LOCK_W'(1);
                now[i] = ~pins[i];
                if (now[i] != sw_on[i] && lock_cnt[i] == '0) fire = 1'b1;
            end
            if (!fire) return;
            // every differing switch reports, locked or not
            foreach (now[i]) begin
                if (now[i] != sw_on[i]) begin
                    sum         = {1'b0, base_note} + {1'b0, interval[i]};
                    msg.note_on = now[i];
                    msg.chan    = channel;
                    msg.note    = (sum > 8'd127) ? 7'd127 : sum[slmn_pkg::NOTE_W-1:0];
                    msg.vel     = velocity;
                    msg.sw      = slmn_pkg::IDX_W'(i);
                    msg.last    = 1'b0;
                    burst.push_back(msg);
                    sw_on[i]    = now[i];
                    lock_cnt[i] = lock_ticks;
                end
            end
            burst[burst.size()-1].last = 1'b1;
            foreach (burst[k]) pending_notes.push_back(burst[k]);
        endfunction

        function void check_note(t_note_msg got);
            t_note_msg want;
            logic      bad;
            if (pending_notes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected note: on=%0d ch=%0d note=%0d vel=%0d sw=%0d last=%0d",
                             got.note_on, got.chan, got.note, got.vel, got.sw, got.last);
                return;
            end
            want = pending_notes.pop_front();
            bad  = (got.note_on !== want.note_on) || (got.chan !== want.chan) ||
                   (got.note !== want.note) || (got.vel !== want.vel) ||
                   (got.sw !== want.sw) || (got.last !== want.last);
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display("note mismatch exp: on=%0d ch=%0d note=%0d vel=%0d sw=%0d last=%0d",
                             want.note_on, want.chan, want.note, want.vel, want.sw, want.last);
                    $display("              got: on=%0d ch=%0d note=%0d vel=%0d sw=%0d last=%0d",
                             got.note_on, got.chan, got.note, got.vel, got.sw, got.last);
                end
            end
        endfunction
    endclass

endpackage

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 12;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} t_rx_mode;

    logic                              i_clk        = 1'b0;
    logic                              i_rst_n      = 1'b0;
    logic                              i_valid      = 1'b0;
    logic [slmn_pkg::MAX_SWITCHES-1:0] i_pin_levels = '1;
    logic                              i_stall      = 1'b0;
    logic                              i_cfg_we     = 1'b0;
    slmn_pkg::t_cfg_idx                i_cfg_index  = slmn_pkg::CFG_LOCKOUT_TICKS;
    logic [slmn_pkg::CFG_W-1:0]        i_cfg_data   = '0;

    logic                              o_stall;
    logic                              o_valid;
    logic                              o_note_on;
    logic [slmn_pkg::CHAN_W-1:0]       o_channel_out;
    logic [slmn_pkg::NOTE_W-1:0]       o_note_number;
    logic [slmn_pkg::NOTE_W-1:0]       o_velocity_out;
    logic [slmn_pkg::IDX_W-1:0]        o_switch_index;
    logic                              o_last;

    midi_note_board_pkg::midi_note_board board;
    midi_note_board_pkg::t_note_msg      seen_note;
    int                                  cycles     = 0;
    int                                  burst_left = 0;
    int                                  hold_left  = 0;
    int                                  mode_left  = 0;
    bit                                  hold_req   = 1'b0;
    t_rx_mode                            rx_mode    = RX_FREE;
    logic [slmn_pkg::MAX_SWITCHES-1:0]   last_pins  = '1;

    switch_lockout_midi_note_events dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pin_levels   (i_pin_levels),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_note_on      (o_note_on),
        .o_channel_out  (o_channel_out),
        .o_note_number  (o_note_number),
        .o_velocity_out (o_velocity_out),
        .o_switch_index (o_switch_index),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            seen_note.note_on = o_note_on;
            seen_note.chan    = o_channel_out;
            seen_note.note    = o_note_number;
            seen_note.vel     = o_velocity_out;
            seen_note.sw      = o_switch_index;
            seen_note.last    = o_last;
            board.check_note(seen_note);
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 80);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_FREE:  i_stall <= 1'b0;
                RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: i_stall <= ($urandom_range(0, 9) < 6);
                default:  i_stall <= ~i_stall;
            endcase
        end
    end

    function automatic logic [slmn_pkg::CFG_W-1:0] rnd_cfg(input int unsigned lo,
                                                          input int unsigned hi);
        return slmn_pkg::CFG_W'($urandom_range(lo, hi));
    endfunction

    task automatic send_tick(input logic [slmn_pkg::MAX_SWITCHES-1:0] pins);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_pin_levels <= pins;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        board.take_tick(pins);
        last_pins = pins;
    endtask

    task automatic wait_empty(input int settle);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_notes.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic cfg_write(input slmn_pkg::t_cfg_idx idx,
                             input logic [slmn_pkg::CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    task automatic configure(input logic [slmn_pkg::CFG_W-1:0] lock,
                             input logic [slmn_pkg::CFG_W-1:0] base,
                             input logic [slmn_pkg::CFG_W-1:0] vel,
                             input logic [slmn_pkg::CFG_W-1:0] chan);
        cfg_write(slmn_pkg::CFG_LOCKOUT_TICKS, lock);
        cfg_write(slmn_pkg::CFG_BASE_NOTE, base);
        cfg_write(slmn_pkg::CFG_NOTE_VELOCITY, vel);
        cfg_write(slmn_pkg::CFG_MIDI_CHANNEL, chan);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count);
        logic [slmn_pkg::MAX_SWITCHES-1:0] pins;
        logic [slmn_pkg::IDX_W-1:0]        flip;
        int                                pick;
        repeat (count) begin
            pick = $urandom_range(0, 9);
            pins = last_pins;
            // hold or flip a single switch equally often, scramble rarely
            if (pick >= 4 && pick <= 7) begin
                flip       = slmn_pkg::IDX_W'($urandom_range(0, slmn_pkg::MAX_SWITCHES-1));
                pins[flip] = ~pins[flip];
            end else if (pick == 8)
                pins ^= slmn_pkg::MAX_SWITCHES'($urandom);
            else if (pick == 9)
                pins = slmn_pkg::MAX_SWITCHES'($urandom);
            send_tick(pins);
        end
    endtask

    initial begin
        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_tick(8'hFF);
        send_tick(8'hFE);
        send_tick(8'hFF);
        send_tick(8'hFD);

        wait_empty(SETTLE_CYCLES);
        configure(16'd0, 16'd127, 16'd0, 16'd15);
        send_tick(8'hFF);
        send_tick(8'h00);
        send_tick(8'h55);
        send_tick(8'hAA);
        send_tick(8'h0F);
        send_tick(8'hF0);
        send_tick(8'h80);
        send_tick(8'h7F);

        wait_empty(SETTLE_CYCLES);
        configure(16'd2, 16'd0, 16'd1, 16'd1);
        send_tick(8'h00);
        send_tick(8'hFF);
        send_tick(8'hFE);
        send_tick(8'h01);

        for (int ph = 0; ph < 6; ph++) begin
            wait_empty(SETTLE_CYCLES);
            case (ph)
                0: configure(16'd1, 16'd115, rnd_cfg(0, 127), rnd_cfg(0, 15));
                1: configure(16'd0, rnd_cfg(0, 127), rnd_cfg(0, 127), rnd_cfg(0, 15));
                2: configure(16'd3, 16'd127, rnd_cfg(0, 127), rnd_cfg(0, 15));
                3: configure(rnd_cfg(1, 6), 16'd0, rnd_cfg(0, 127), rnd_cfg(0, 15));
                4: configure(rnd_cfg(1, 8), rnd_cfg(100, 127), rnd_cfg(0, 127),
                             rnd_cfg(0, 15));
                default: configure(16'hFFFF, rnd_cfg(0, 127), rnd_cfg(0, 127),
                                   rnd_cfg(0, 15));
            endcase
            // back up the output while input keeps coming
            if (ph == 1) hold_req = 1'b1;
            run_random(21);
            if (ph == 2) wait_empty(0);
            run_random(21);
        end

        wait_empty(2 * SETTLE_CYCLES);
        if (board.errors == 0 && board.pending_notes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
